>>> hw/rtl/sff_pkg.sv
// Shared types and codes for the scanline flood fill block.
package sff_pkg;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_FILL  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic [3:0] t_op;
    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_ITEM_WR   = 4'd1;
    localparam t_op OP_ITEM_RD   = 4'd2;
    localparam t_op OP_FILL_INIT = 4'd3;
    localparam t_op OP_POP       = 4'd4;
    localparam t_op OP_SEED_LD   = 4'd5;
    localparam t_op OP_LEFT      = 4'd6;
    localparam t_op OP_RSTART    = 4'd7;
    localparam t_op OP_RIGHT     = 4'd8;
    localparam t_op OP_REND      = 4'd9;
    localparam t_op OP_SROW      = 4'd10;
    localparam t_op OP_SCAN      = 4'd11;

    // signed column/row so that one past either edge is representable
    typedef logic signed [9:0] t_coord;

    typedef struct packed {
        t_op        op;
        logic       row_up;
        logic       fin;
        logic [1:0] fin_status;
        logic       fin_rd;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       outside;
        logic       same;
        logic       match;
        logic       sp_zero;
        logic       sp_full;
        logic       left_more;
        logic       right_more;
        logic       rstart_ok;
        logic       below_ok;
        logic       above_ok;
        logic       span_ok;
        logic       scan_more;
        logic       in_run;
    } t_sts;

endpackage

>>> hw/rtl/sff_ctrl.sv
// Sequencer for requests and the scanline fill walk.
module sff_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  sff_pkg::t_sts i_sts,
    output sff_pkg::t_cmd o_cmd,
    output logic          o_idle
);
    import sff_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_FTGT   = 4'd3;
    localparam logic [3:0] S_POP    = 4'd4;
    localparam logic [3:0] S_SEED   = 4'd5;
    localparam logic [3:0] S_LEFT   = 4'd6;
    localparam logic [3:0] S_RSTART = 4'd7;
    localparam logic [3:0] S_RIGHT  = 4'd8;
    localparam logic [3:0] S_REND   = 4'd9;
    localparam logic [3:0] S_ROW_B  = 4'd10;
    localparam logic [3:0] S_SCAN_B = 4'd11;
    localparam logic [3:0] S_ROW_A  = 4'd12;
    localparam logic [3:0] S_SCAN_A = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (i_sts.kind) inside
                    KIND_WRITE, KIND_READ, KIND_FILL: begin
                        if (i_sts.outside) begin
                            cmd.fin        = 1'b1;
                            cmd.fin_status = ST_OUTSIDE;
                        end else if (i_sts.kind == KIND_WRITE) begin
                            cmd.op  = OP_ITEM_WR;
                            cmd.fin = 1'b1;
                        end else begin
                            cmd.op  = OP_ITEM_RD;
                            n_state = (i_sts.kind == KIND_READ) ? S_RD : S_FTGT;
                        end
                    end
                    default: begin
                        cmd.fin = 1'b1;
                    end
                endcase
            end
            S_RD: begin
                cmd.fin    = 1'b1;
                cmd.fin_rd = 1'b1;
                n_state    = S_IDLE;
            end
            S_FTGT: begin
                if (i_sts.same) begin
                    cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    cmd.op  = OP_FILL_INIT;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_sts.sp_zero) begin
                    cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    cmd.op  = OP_POP;
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                cmd.op  = OP_SEED_LD;
                n_state = S_LEFT;
            end
            S_LEFT: begin
                cmd.op = OP_LEFT;
                if (!(i_sts.match && i_sts.left_more)) begin
                    n_state = S_RSTART;
                end
            end
            S_RSTART: begin
                cmd.op  = OP_RSTART;
                n_state = i_sts.rstart_ok ? S_RIGHT : S_REND;
            end
            S_RIGHT: begin
                cmd.op = OP_RIGHT;
                if (!(i_sts.match && i_sts.right_more)) begin
                    n_state = S_REND;
                end
            end
            S_REND: begin
                cmd.op  = OP_REND;
                n_state = S_ROW_B;
            end
            S_ROW_B: begin
                if (i_sts.below_ok && i_sts.span_ok) begin
                    cmd.op  = OP_SROW;
                    n_state = S_SCAN_B;
                end else begin
                    n_state = S_ROW_A;
                end
            end
            S_ROW_A: begin
                if (i_sts.above_ok && i_sts.span_ok) begin
                    cmd.op     = OP_SROW;
                    cmd.row_up = 1'b1;
                    n_state    = S_SCAN_A;
                end else begin
                    n_state = S_POP;
                end
            end
            S_SCAN_B, S_SCAN_A: begin
                if (i_sts.match && !i_sts.in_run && i_sts.sp_full) begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = ST_OVERFLOW;
                    n_state        = S_IDLE;
                end else begin
                    cmd.op = OP_SCAN;
                    if (!i_sts.scan_more) begin
                        n_state = (r_state == S_SCAN_B) ? S_ROW_A : S_POP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_idle = (r_state == S_IDLE);

endmodule

>>> hw/rtl/sff_datapath.sv
// Pixel memory, seed stack, span registers and result register.
module sff_datapath #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int STACK_DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [8:0]    i_cfg_data,
    input  logic          i_load,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_col,
    input  logic [7:0]    i_row,
    input  logic [31:0]   i_color,
    input  sff_pkg::t_cmd i_cmd,
    output sff_pkg::t_sts o_sts,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [31:0]   o_pixel_value,
    output logic [1:0]    o_status
);
    import sff_pkg::*;

    localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PAW       = $clog2(PIX_DEPTH);
    localparam int SAW       = $clog2(STACK_DEPTH);
    localparam int SPW       = $clog2(STACK_DEPTH + 1);

    logic [8:0]     r_cfg_w;
    logic [8:0]     r_cfg_h;
    logic [1:0]     r_kind;
    logic [7:0]     r_col;
    logic [7:0]     r_row;
    logic [31:0]    r_color;
    logic [31:0]    r_target;
    logic [SPW-1:0] r_sp;
    logic [7:0]     r_pc;
    logic [7:0]     r_pr;
    logic [7:0]     r_srow;
    t_coord         r_cur;
    t_coord         r_lo;
    t_coord         r_hi;
    logic           r_in_run;
    logic           r_out_valid;
    logic [31:0]    r_value;
    logic [1:0]     r_status;

    logic [31:0]    r_pix_mem [PIX_DEPTH];
    logic [31:0]    r_pix_q;
    logic [15:0]    r_stk_mem [STACK_DEPTH];
    logic [15:0]    r_stk_q;

    logic [8:0]     uw;
    logic [8:0]     uh;
    t_coord         cur_m1;
    t_coord         cur_p1;
    logic           match;
    logic           push;
    logic           pix_we;
    logic [PAW-1:0] pix_wa;
    logic [PAW-1:0] pix_ra;
    logic           stk_we;
    logic [SAW-1:0] stk_wa;
    logic [15:0]    stk_wd;
    logic [SAW-1:0] stk_ra;
    logic [7:0]     row_nb;

    function automatic logic [PAW-1:0] f_addr(input logic [7:0] c, input logic [7:0] r);
        f_addr = PAW'(32'(r) * MAX_WIDTH + 32'(c));
    endfunction

    assign uw     = (32'(r_cfg_w) > MAX_WIDTH) ? 9'(MAX_WIDTH) : r_cfg_w;
    assign uh     = (32'(r_cfg_h) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : r_cfg_h;
    assign cur_m1 = r_cur - 10'sd1;
    assign cur_p1 = r_cur + 10'sd1;
    assign match  = (r_pix_q == r_target);
    assign push   = (i_cmd.op == OP_SCAN) && match && !r_in_run;
    assign row_nb = i_cmd.row_up ? (r_pr - 8'd1) : (r_pr + 8'd1);

    always_comb begin
        o_sts            = '0;
        o_sts.kind       = r_kind;
        o_sts.outside    = ({1'b0, r_col} >= uw) || ({1'b0, r_row} >= uh);
        o_sts.same       = (r_pix_q == r_color);
        o_sts.match      = match;
        o_sts.sp_zero    = (r_sp == '0);
        o_sts.sp_full    = (r_sp == SPW'(STACK_DEPTH));
        o_sts.left_more  = (r_cur >= 10'sd1);
        o_sts.right_more = (cur_p1 < $signed({1'b0, uw}));
        o_sts.rstart_ok  = (({2'b0, r_pc} + 10'd1) < {1'b0, uw});
        o_sts.below_ok   = (({2'b0, r_pr} + 10'd1) < {1'b0, uh});
        o_sts.above_ok   = (r_pr != 8'd0);
        o_sts.span_ok    = (r_lo <= r_hi);
        o_sts.scan_more  = (r_cur < r_hi);
        o_sts.in_run     = r_in_run;
    end

    always_comb begin
        pix_we = 1'b0;
        pix_wa = f_addr(r_cur[7:0], r_pr);
        pix_ra = f_addr(r_col, r_row);
        case (i_cmd.op)
            OP_ITEM_WR: begin
                pix_we = 1'b1;
                pix_wa = f_addr(r_col, r_row);
            end
            OP_SEED_LD: begin
                pix_ra = f_addr(r_stk_q[7:0], r_stk_q[15:8]);
            end
            OP_LEFT: begin
                pix_we = match;
                pix_ra = f_addr(cur_m1[7:0], r_pr);
            end
            OP_RSTART: begin
                pix_ra = f_addr(r_pc + 8'd1, r_pr);
            end
            OP_RIGHT: begin
                pix_we = match;
                pix_ra = f_addr(cur_p1[7:0], r_pr);
            end
            OP_SROW: begin
                pix_ra = f_addr(r_lo[7:0], row_nb);
            end
            OP_SCAN: begin
                pix_ra = f_addr(cur_p1[7:0], r_srow);
            end
            default: begin
            end
        endcase
    end

    assign stk_we = (i_cmd.op == OP_FILL_INIT) || push;
    assign stk_wa = (i_cmd.op == OP_FILL_INIT) ? '0 : SAW'(r_sp);
    assign stk_wd = (i_cmd.op == OP_FILL_INIT) ? {r_row, r_col} : {r_srow, r_cur[7:0]};
    assign stk_ra = SAW'(r_sp - SPW'(1));

    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            r_pix_mem[pix_wa] <= r_color;
        end
        r_pix_q <= r_pix_mem[pix_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_q <= r_stk_mem[stk_ra];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= 9'd256;
            r_cfg_h     <= 9'd256;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_cfg_w <= i_cfg_data;
                end else begin
                    r_cfg_h <= i_cfg_data;
                end
            end
            if (i_cmd.op == OP_FILL_INIT) begin
                r_sp <= SPW'(1);
            end else if (i_cmd.op == OP_POP) begin
                r_sp <= r_sp - SPW'(1);
            end else if (push) begin
                r_sp <= r_sp + SPW'(1);
            end
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind  <= i_kind;
            r_col   <= i_col;
            r_row   <= i_row;
            r_color <= i_color;
        end
        if (i_cmd.fin) begin
            r_status <= i_cmd.fin_status;
            r_value  <= i_cmd.fin_rd ? r_pix_q : 32'd0;
        end
        case (i_cmd.op)
            OP_FILL_INIT: r_target <= r_pix_q;
            OP_SEED_LD: begin
                r_pc  <= r_stk_q[7:0];
                r_pr  <= r_stk_q[15:8];
                r_cur <= t_coord'({2'b0, r_stk_q[7:0]});
            end
            OP_LEFT: begin
                if (match) begin
                    r_cur <= cur_m1;
                end
            end
            OP_RSTART: begin
                r_lo  <= cur_p1;
                r_cur <= t_coord'({2'b0, r_pc}) + 10'sd1;
            end
            OP_RIGHT: begin
                if (match) begin
                    r_cur <= cur_p1;
                end
            end
            OP_REND: r_hi <= cur_m1;
            OP_SROW: begin
                r_srow   <= row_nb;
                r_cur    <= r_lo;
                r_in_run <= 1'b0;
            end
            OP_SCAN: begin
                r_in_run <= match;
                r_cur    <= cur_p1;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_value;
    assign o_status      = r_status;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("seed stack pointer past depth");

    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> r_out_valid)
        else $error("finished item did not raise result valid");

    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> !(r_out_valid && i_out_stall))
        else $error("result overwritten while still pending");

endmodule

>>> hw/rtl/scanline_flood_fill.sv
// Scanline flood fill engine: top level.
// One request at a time. The time a fill takes grows with each pixel it
// recolors or scans and with each popped seed, set by the single read
// port of the pixel memory. A new request is taken once the previous
// result has been transferred or is transferring. The pixel memory and
// seed stack need no clearing pass after reset. The user must see that
// canvas size registers are written only idle; the block does not enforce it.
module scanline_flood_fill #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int STACK_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_col,
    input  logic [7:0]  i_row,
    input  logic [31:0] i_color,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_pixel_value,
    output logic [1:0]  o_status
);
    import sff_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic idle;
    logic accept;

    assign o_in_stall = !idle || (o_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    sff_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    sff_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_load        (accept),
        .i_kind        (i_kind),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_color       (i_color),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pixel_value (o_pixel_value),
        .o_status      (o_status)
    );

endmodule
